[rtl/tpba_pkg.sv]
// shared types, codes and reset constants of the two-pool bump allocator
package tpba_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 64;

  localparam logic [31:0] FAST_START_RST = 32'h0300_0000;
  localparam logic [31:0] FAST_END_RST   = 32'h0300_7800;
  localparam logic [31:0] SLOW_START_RST = 32'h0200_0000;
  localparam logic [31:0] SLOW_END_RST   = 32'h0204_0000;

  // item kinds
  localparam logic [2:0] KIND_CACHED_FAST = 3'd0;
  localparam logic [2:0] KIND_CACHED_SLOW = 3'd1;
  localparam logic [2:0] KIND_FAST        = 3'd2;
  localparam logic [2:0] KIND_SLOW        = 3'd3;
  localparam logic [2:0] KIND_RESTART     = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_FAST_START = 2'd0;
  localparam logic [1:0] CFG_FAST_END   = 2'd1;
  localparam logic [1:0] CFG_SLOW_START = 2'd2;
  localparam logic [1:0] CFG_SLOW_END   = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  slot;
    logic [23:0] request_bytes;
  } tpba_item_t;

  typedef struct packed {
    logic [31:0] address;
    logic        failed;
    logic        from_slot;
    logic [31:0] fast_left;
    logic [31:0] slow_left;
  } tpba_result_t;

  // slot table write request
  typedef struct packed {
    logic        en;
    logic [5:0]  slot;
    logic [31:0] data;
  } tpba_wr_t;

endpackage

[rtl/tpba_slot_mem.sv]
// slot table memory with registered read, write forwarding and clearing sweep
module tpba_slot_mem import tpba_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rd_en_i,
  input  logic [5:0]  rd_slot_i,
  input  tpba_wr_t    wr_i,
  input  logic        clear_i,
  output logic        clearing_o,
  output logic [31:0] rdata_o
);

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);

  logic [31:0]      mem [SLOT_COUNT];
  logic [31:0]      rdata_q;
  logic             clearing_q, clearing_d;
  logic [IDX_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [IDX_W-1:0] rd_idx, wr_idx;

  assign rd_idx = IDX_W'(rd_slot_i);
  assign wr_idx = IDX_W'(wr_i.slot);

  always_comb begin
    clearing_d = clearing_q;
    clr_cnt_d  = clr_cnt_q;
    if (clear_i) begin
      clearing_d = 1'b1;
      clr_cnt_d  = '0;
    end else if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + IDX_W'(1);
      if (clr_cnt_q == IDX_W'(SLOT_COUNT - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  // sweep starts right out of reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (wr_i.en) begin
      mem[wr_idx] <= wr_i.data;
    end
  end

  // forward a same-cycle write to the following read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.en && wr_idx == rd_idx) begin
        rdata_q <= wr_i.data;
      end else begin
        rdata_q <= mem[rd_idx];
      end
    end
  end

  assign clearing_o = clearing_q;
  assign rdata_o    = rdata_q;

endmodule

[rtl/two_pool_bump_allocator_core.sv]
// top level of the two-pool bump allocator with slot table
//
//  channel  | signals                                  | handshake
//  ---------+------------------------------------------+--------------------------
//  item     | start, busy, item_i                      | start & !busy
//  result   | done_o, result_o                         | done_o, one cycle, no stall
//  config   | cfg_valid_i, cfg_ready_o, cfg_index_i,   | cfg_valid_i & cfg_ready_o
//           | cfg_data_i                               |
//
// an item is registered together with its slot table read, worked in the next
// cycle and its result is registered into res_q and done_o; one item per cycle while busy is low.
// after reset and after every restart item the slot table is swept to zero,
// one entry a cycle; busy is high through the sweep and in the cycle a
// restart is worked. config is always ready. results cannot stall.
module two_pool_bump_allocator_core import tpba_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  tpba_item_t   item_i,
  output logic         done_o,
  output tpba_result_t result_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  logic [31:0] fast_start_q, fast_end_q, slow_start_q, slow_end_q;
  logic [31:0] fast_next_q, fast_next_d, slow_next_q, slow_next_d;
  logic        in_valid_q;
  tpba_item_t  item_q;
  logic        done_q;
  tpba_result_t res_q, res_d;
  logic        accept;
  logic        clearing;
  logic        restart;
  logic [31:0] rdata;
  tpba_wr_t    wr;

  logic [24:0] size;
  logic [32:0] fast_sum, slow_sum;
  logic        fast_ok, slow_ok;
  logic        fast_first, cached, hit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_start_q <= FAST_START_RST;
      fast_end_q   <= FAST_END_RST;
      slow_start_q <= SLOW_START_RST;
      slow_end_q   <= SLOW_END_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FAST_START: fast_start_q <= cfg_data_i;
        CFG_FAST_END:   fast_end_q   <= cfg_data_i;
        CFG_SLOW_START: slow_start_q <= cfg_data_i;
        CFG_SLOW_END:   slow_end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign restart = in_valid_q && (item_q.kind == KIND_RESTART);
  assign busy    = clearing || restart;
  assign accept  = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  tpba_slot_mem #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_slot_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_slot_i  (item_i.slot),
    .wr_i       (wr),
    .clear_i    (restart),
    .clearing_o (clearing),
    .rdata_o    (rdata)
  );

  // round up to whole words; 33-bit sums keep the carry as no room
  assign size     = (25'(item_q.request_bytes) + 25'd3) & ~25'd3;
  assign fast_sum = {1'b0, fast_next_q} + 33'(size);
  assign slow_sum = {1'b0, slow_next_q} + 33'(size);
  assign fast_ok  = fast_sum < {1'b0, fast_end_q};
  assign slow_ok  = slow_sum < {1'b0, slow_end_q};

  assign fast_first = (item_q.kind == KIND_CACHED_FAST) || (item_q.kind == KIND_FAST);
  assign cached     = ((item_q.kind == KIND_CACHED_FAST) || (item_q.kind == KIND_CACHED_SLOW))
                      && (item_q.slot >= 6'd2) && (32'(item_q.slot) < SLOT_COUNT);
  assign hit        = cached && (rdata != '0);

  always_comb begin
    fast_next_d   = fast_next_q;
    slow_next_d   = slow_next_q;
    res_d.address   = '0;
    res_d.failed    = 1'b0;
    res_d.from_slot = 1'b0;
    wr.en   = 1'b0;
    wr.slot = item_q.slot;
    wr.data = '0;
    if (in_valid_q) begin
      case (item_q.kind) inside
        KIND_CACHED_FAST, KIND_CACHED_SLOW, KIND_FAST, KIND_SLOW: begin
          if (hit) begin
            res_d.address   = rdata;
            res_d.from_slot = 1'b1;
          end else if (fast_first && fast_ok) begin
            res_d.address = fast_next_q;
            fast_next_d   = fast_sum[31:0];
          end else if (slow_ok) begin
            res_d.address = slow_next_q;
            slow_next_d   = slow_sum[31:0];
          end else if (!fast_first && fast_ok) begin
            res_d.address = fast_next_q;
            fast_next_d   = fast_sum[31:0];
          end else begin
            res_d.failed = 1'b1;
          end
          wr.en   = cached && !hit && !res_d.failed;
          wr.data = res_d.address;
        end
        KIND_RESTART: begin
          fast_next_d = fast_start_q;
          slow_next_d = slow_start_q;
        end
        default: ;
      endcase
    end
    res_d.fast_left = fast_end_q - fast_next_d;
    res_d.slow_left = slow_end_q - slow_next_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_next_q <= FAST_START_RST;
      slow_next_q <= SLOW_START_RST;
      done_q      <= 1'b0;
    end else begin
      fast_next_q <= fast_next_d;
      slow_next_q <= slow_next_d;
      done_q      <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

[tb/two_pool_bump_allocator_core_tb.sv]
// self-checking testbench for the two-pool bump allocator core
`timescale 1ns / 1ps

module two_pool_bump_allocator_core_tb;
  import tpba_pkg::*;

  // kinds that the block must treat as no-ops
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_MID = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam logic [5:0] SLOT_FIRST = 6'd2;
  localparam int unsigned NUM_PHASES = 4;
  localparam int unsigned RAND_PER_PHASE = 150;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic         typed;
    tpba_item_t   it;
    tpba_result_t res;
  } stim_row_t;

  // directed rows, typed results only where they are obvious from reset values
  localparam stim_row_t DIR_ROWS [21] = '{
    '{1'b1, '{KIND_FAST, 6'd0, 24'd0},
      '{32'h0300_0000, 1'b0, 1'b0, 32'h0000_7800, 32'h0004_0000}},
    '{1'b1, '{KIND_FAST, 6'd0, 24'd1},
      '{32'h0300_0000, 1'b0, 1'b0, 32'h0000_77FC, 32'h0004_0000}},
    '{1'b1, '{KIND_SLOW, 6'd63, 24'd3},
      '{32'h0200_0000, 1'b0, 1'b0, 32'h0000_77FC, 32'h0003_FFFC}},
    '{1'b1, '{KIND_FAST, 6'd21, 24'hFF_FFFF},
      '{32'h0000_0000, 1'b1, 1'b0, 32'h0000_77FC, 32'h0003_FFFC}},
    '{1'b1, '{KIND_SLOW, 6'd42, 24'hFF_FFFF},
      '{32'h0000_0000, 1'b1, 1'b0, 32'h0000_77FC, 32'h0003_FFFC}},
    '{1'b0, '{KIND_CACHED_FAST, 6'd63, 24'd5}, '0},
    '{1'b0, '{KIND_CACHED_SLOW, 6'd63, 24'd100}, '0},
    '{1'b0, '{KIND_CACHED_SLOW, 6'd2, 24'h03_FFF8}, '0},
    '{1'b0, '{KIND_CACHED_SLOW, 6'd2, 24'd8}, '0},
    '{1'b0, '{KIND_SLOW, 6'd0, 24'd0}, '0},
    '{1'b0, '{KIND_SLOW, 6'd0, 24'd4}, '0},
    '{1'b0, '{KIND_CACHED_FAST, 6'd0, 24'd8}, '0},
    '{1'b0, '{KIND_CACHED_SLOW, 6'd1, 24'd8}, '0},
    '{1'b0, '{KIND_SPARE_LO, 6'd63, 24'hFF_FFFF}, '0},
    '{1'b0, '{KIND_SPARE_MID, 6'd21, 24'h55_5555}, '0},
    '{1'b0, '{KIND_SPARE_HI, 6'd2, 24'hAA_AAAA}, '0},
    '{1'b0, '{KIND_FAST, 6'd0, 24'h00_7000}, '0},
    '{1'b0, '{KIND_FAST, 6'd0, 24'h00_1000}, '0},
    '{1'b1, '{KIND_RESTART, 6'd0, 24'd0},
      '{32'h0000_0000, 1'b0, 1'b0, 32'h0000_7800, 32'h0004_0000}},
    '{1'b0, '{KIND_CACHED_FAST, 6'd63, 24'd12}, '0},
    '{1'b0, '{KIND_CACHED_FAST, 6'd63, 24'd0}, '0}
  };

  // pool settings per phase: fast start, fast end, slow start, slow end
  localparam logic [31:0] POOL_CFG [NUM_PHASES][4] = '{
    '{FAST_START_RST, FAST_END_RST, SLOW_START_RST, SLOW_END_RST},
    '{32'h0000_1000, 32'h0000_1400, 32'h0000_2000, 32'h0000_2800},
    '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_F000, 32'hFFFF_FFFF},
    '{32'h0000_0100, 32'h0000_0000, 32'h8000_0000, 32'h8000_4000}
  };
  localparam int unsigned SEND_IDLE_PCT [NUM_PHASES] = '{0, 51, 0, 36};

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         start = 1'b0;
  logic         busy;
  tpba_item_t   item_i = '0;
  logic         done_o;
  tpba_result_t result_o;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;

  // shadow of the allocator
  logic [31:0] fast_base, fast_limit, slow_base, slow_limit;
  logic [31:0] fast_ptr, slow_ptr;
  logic [31:0] slot_mem [SLOT_COUNT_DEF];

  tpba_result_t pending_results [$];
  int unsigned  err_cnt = 0;
  int unsigned  idle_pct = 0;

  two_pool_bump_allocator_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // the sum is 33 bits wide so a carry out always means no room
  function automatic bit pool_take(inout logic [31:0] ptr, input logic [31:0] lim,
                                   input logic [31:0] size, output logic [31:0] addr);
    logic [32:0] sum;
    sum = {1'b0, ptr} + {1'b0, size};
    addr = '0;
    if (sum >= {1'b0, lim}) return 1'b0;
    addr = ptr;
    ptr = sum[31:0];
    return 1'b1;
  endfunction

  function automatic tpba_result_t alloc_predict(input tpba_item_t it);
    tpba_result_t r;
    logic [31:0]  size, addr;
    bit           cached, ok;
    r = '0;
    addr = '0;
    if (it.kind <= KIND_SLOW) begin
      cached = (it.kind <= KIND_CACHED_SLOW) && (it.slot >= SLOT_FIRST) &&
               (int'(it.slot) < SLOT_COUNT_DEF);
      if (cached && slot_mem[it.slot] != '0) begin
        r.address = slot_mem[it.slot];
        r.from_slot = 1'b1;
      end else begin
        size = ({8'h00, it.request_bytes} + 32'd3) & ~32'd3;
        if (it.kind == KIND_CACHED_FAST || it.kind == KIND_FAST) begin
          ok = pool_take(fast_ptr, fast_limit, size, addr);
          if (!ok) ok = pool_take(slow_ptr, slow_limit, size, addr);
        end else begin
          ok = pool_take(slow_ptr, slow_limit, size, addr);
          if (!ok) ok = pool_take(fast_ptr, fast_limit, size, addr);
        end
        if (ok) begin
          r.address = addr;
          // a zero address stored here still reads back as empty
          if (cached) slot_mem[it.slot] = addr;
        end else begin
          r.failed = 1'b1;
        end
      end
    end else if (it.kind == KIND_RESTART) begin
      fast_ptr = fast_base;
      slow_ptr = slow_base;
      foreach (slot_mem[i]) slot_mem[i] = '0;
    end
    r.fast_left = fast_limit - fast_ptr;
    r.slow_left = slow_limit - slow_ptr;
    return r;
  endfunction

  task automatic push_item(input tpba_item_t it, input bit typed, input tpba_result_t typed_res);
    tpba_result_t predicted;
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = alloc_predict(it);
    pending_results.push_back(typed ? typed_res : predicted);
    // each following cycle is idle with the phase's odds
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic program_pools(input int p);
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= 2'(i);
      cfg_data_i <= POOL_CFG[p][i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (2'(i))
        CFG_FAST_START: fast_base = POOL_CFG[p][i];
        CFG_FAST_END:   fast_limit = POOL_CFG[p][i];
        CFG_SLOW_START: slow_base = POOL_CFG[p][i];
        CFG_SLOW_END:   slow_limit = POOL_CFG[p][i];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic tpba_item_t rand_item();
    tpba_item_t it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3) it.kind = KIND_RESTART;
    else if (pick < 5) it.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    else if (pick < 45) it.kind = $urandom_range(1) ? KIND_CACHED_FAST : KIND_CACHED_SLOW;
    else it.kind = $urandom_range(1) ? KIND_FAST : KIND_SLOW;
    // a narrow slot range keeps hits on earlier entries frequent
    if ($urandom_range(99) < 80) it.slot = 6'($urandom_range(2, 9));
    else it.slot = 6'($urandom_range(0, 63));
    pick = $urandom_range(99);
    if (pick < 60) it.request_bytes = 24'($urandom_range(0, 64));
    else if (pick < 90) it.request_bytes = 24'($urandom_range(0, 4095));
    else it.request_bytes = 24'($urandom());
    return it;
  endfunction

  // each result beat is checked against the oldest expectation
  always @(posedge clk_i) begin
    tpba_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("unexpected result beat: addr %h failed %b from_slot %b", result_o.address,
                   result_o.failed, result_o.from_slot);
      end else begin
        want = pending_results.pop_front();
        if (result_o.address !== want.address || result_o.failed !== want.failed ||
            result_o.from_slot !== want.from_slot || result_o.fast_left !== want.fast_left ||
            result_o.slow_left !== want.slow_left) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("mismatch at %0t", $realtime);
            $display("  exp addr %h failed %b from_slot %b fast_left %h slow_left %h",
                     want.address, want.failed, want.from_slot, want.fast_left,
                     want.slow_left);
            $display("  got addr %h failed %b from_slot %b fast_left %h slow_left %h",
                     result_o.address, result_o.failed, result_o.from_slot,
                     result_o.fast_left, result_o.slow_left);
          end
        end
      end
    end
  end

  initial begin
    fast_base = FAST_START_RST;
    fast_limit = FAST_END_RST;
    slow_base = SLOW_START_RST;
    slow_limit = SLOW_END_RST;
    fast_ptr = FAST_START_RST;
    slow_ptr = SLOW_START_RST;
    foreach (slot_mem[i]) slot_mem[i] = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_ROWS[i]) push_item(DIR_ROWS[i].it, DIR_ROWS[i].typed, DIR_ROWS[i].res);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      program_pools(p);
      idle_pct = SEND_IDLE_PCT[p];
      push_item('{KIND_RESTART, 6'd0, 24'd0}, 1'b0, '0);
      // a zero-size cached allocation, a second request on its slot, a huge request and a low slot
      push_item('{KIND_CACHED_FAST, 6'd5, 24'd0}, 1'b0, '0);
      push_item('{KIND_CACHED_FAST, 6'd5, 24'd8}, 1'b0, '0);
      push_item('{KIND_CACHED_SLOW, 6'd6, 24'hFF_FFFF}, 1'b0, '0);
      push_item('{KIND_CACHED_SLOW, 6'd0, 24'd4}, 1'b0, '0);
      push_item('{KIND_FAST, 6'd0, 24'd0}, 1'b0, '0);
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        push_item(rand_item(), 1'b0, '0);
        // in phase 1 only, hold off once mid-phase until every result is back
        if (p == 1 && i == RAND_PER_PHASE / 2) drain_results();
      end
    end

    drain_results();
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
